FILE: hw/rtl/vdbw_pkg.sv
// Shared constants, request type and address helpers for the deskew warp block.
`default_nettype none

package vdbw_pkg;

    localparam int X_BITS     = 5;
    localparam int Y_BITS     = 5;
    localparam int ADDR_W     = 15;
    localparam int DATA_W     = 16;
    localparam int YB         = X_BITS;
    localparam int ZB         = X_BITS + Y_BITS;
    localparam int BANKS      = 4;
    localparam int BANK_AW    = ADDR_W - 2;
    localparam int BANK_DEPTH = 1 << BANK_AW;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic FUNC_LOAD    = 1'b0;
    localparam logic FUNC_COMPUTE = 1'b1;

    localparam logic [CFG_IDX_W-1:0] REG_YCOEF_Z  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_Y_OFFSET = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ZCOEF_Y  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ZCOEF_Z  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_Z_OFFSET = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_START_X  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_Y_LIMIT  = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_Z_LIMIT  = 3'd7;

    typedef struct packed {
        logic               we;
        logic [BANK_AW-1:0] waddr;
        logic [DATA_W-1:0]  wdata;
        logic               re;
        logic [BANK_AW-1:0] raddr;
    } t_bank_req;

    function automatic logic [1:0] bank_code(input logic [ADDR_W-1:0] a);
        return {a[ZB], a[YB]};
    endfunction

    function automatic logic [BANK_AW-1:0] bank_index(input logic [ADDR_W-1:0] a);
        return {a[ADDR_W-1:ZB+1], a[ZB-1:YB+1], a[YB-1:0]};
    endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/vdbw_bank.sv
// One bank of the source voxel store: one write port and one registered read port.
`default_nettype none

module vdbw_bank (
    input  wire logic                         i_clk,
    input  wire vdbw_pkg::t_bank_req          i_req,
    output logic [vdbw_pkg::DATA_W-1:0]       o_rdata
);

    logic [vdbw_pkg::DATA_W-1:0] r_mem [vdbw_pkg::BANK_DEPTH];
    logic [vdbw_pkg::DATA_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr] <= i_req.wdata;
        end
        if (i_req.re) begin
            r_rdata <= r_mem[i_req.raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

FILE: hw/rtl/volume_deskew_bilinear_warp_top.sv
// Top level of the deskew warp: coordinate mapping, banked source store and bilinear blend.
// A compute request strobes its result after passing stages A to F and the output register.
// A load request writes the store from the stage D registers and gives no result.
// Throughput is one request per cycle while busy is low: four y/z parity banks serve all four neighbours at once.
// Synchronous reset clears the pipeline valid bits and the strobe and sets the configuration registers to their
// defaults; the store keeps its data. Busy is high during reset and until the ready register sets after it.
`default_nettype none

module volume_deskew_bilinear_warp_top (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    input  wire logic                                  i_start,
    output logic                                       o_busy,
    input  wire logic                                  i_func,
    input  wire logic [vdbw_pkg::ADDR_W-1:0]           i_load_addr,
    input  wire logic [vdbw_pkg::DATA_W-1:0]           i_load_data,
    input  wire logic [7:0]                            i_out_x,
    input  wire logic [7:0]                            i_out_y,
    input  wire logic [7:0]                            i_out_z,
    input  wire logic                                  i_cfg_we,
    input  wire logic [vdbw_pkg::CFG_IDX_W-1:0]        i_cfg_idx,
    input  wire logic [vdbw_pkg::CFG_DATA_W-1:0]       i_cfg_wdata,
    output logic                                       o_valid,
    output logic [vdbw_pkg::DATA_W-1:0]                o_voxel_value,
    output logic                                       o_in_range
);

    localparam int PROD_W = 41;
    localparam int TY_W   = PROD_W + 1;
    localparam int TZ_W   = PROD_W + 2;
    localparam int XS_W   = 9;
    localparam int W_W    = 33;
    localparam int T_W    = W_W + vdbw_pkg::DATA_W;
    localparam int AW     = vdbw_pkg::ADDR_W;
    localparam int DW     = vdbw_pkg::DATA_W;

    localparam logic [AW-1:0]  PLANE = AW'(1 << vdbw_pkg::ZB);
    localparam logic [T_W-1:0] ROUND = T_W'(1) << 31;

    // Configuration registers.
    logic [31:0] r_ycoef_z, r_y_offset, r_zcoef_y, r_zcoef_z, r_z_offset;
    logic [4:0]  r_start_x;
    logic [5:0]  r_y_limit, r_z_limit;
    logic        r_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ycoef_z  <= 32'd65536;
            r_y_offset <= '0;
            r_zcoef_y  <= '0;
            r_zcoef_z  <= 32'd65536;
            r_z_offset <= '0;
            r_start_x  <= '0;
            r_y_limit  <= 6'd32;
            r_z_limit  <= 6'd32;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                vdbw_pkg::REG_YCOEF_Z:  r_ycoef_z  <= i_cfg_wdata;
                vdbw_pkg::REG_Y_OFFSET: r_y_offset <= i_cfg_wdata;
                vdbw_pkg::REG_ZCOEF_Y:  r_zcoef_y  <= i_cfg_wdata;
                vdbw_pkg::REG_ZCOEF_Z:  r_zcoef_z  <= i_cfg_wdata;
                vdbw_pkg::REG_Z_OFFSET: r_z_offset <= i_cfg_wdata;
                vdbw_pkg::REG_START_X:  r_start_x  <= i_cfg_wdata[4:0];
                vdbw_pkg::REG_Y_LIMIT:  r_y_limit  <= i_cfg_wdata[5:0];
                vdbw_pkg::REG_Z_LIMIT:  r_z_limit  <= i_cfg_wdata[5:0];
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ready <= 1'b0;
        end else begin
            r_ready <= 1'b1;
        end
    end

    assign o_busy = ~r_ready;

    // Stage A: the three coordinate products.
    logic signed [PROD_W-1:0] ycz_ext, zcy_ext, zcz_ext, y_ext, z_ext;
    logic signed [PROD_W-1:0] n_a_pyz, n_a_pzy, n_a_pzz;
    logic signed [PROD_W-1:0] r_a_pyz, r_a_pzy, r_a_pzz;
    logic                     r_a_vld, r_a_func;
    logic [AW-1:0]            r_a_laddr;
    logic [DW-1:0]            r_a_ldata;
    logic [7:0]               r_a_x;

    assign ycz_ext = {{(PROD_W-32){r_ycoef_z[31]}}, r_ycoef_z};
    assign zcy_ext = {{(PROD_W-32){r_zcoef_y[31]}}, r_zcoef_y};
    assign zcz_ext = {{(PROD_W-32){r_zcoef_z[31]}}, r_zcoef_z};
    assign y_ext   = {{(PROD_W-8){1'b0}}, i_out_y};
    assign z_ext   = {{(PROD_W-8){1'b0}}, i_out_z};

    always_comb begin
        n_a_pyz = ycz_ext * z_ext;
        n_a_pzy = zcy_ext * y_ext;
        n_a_pzz = zcz_ext * z_ext;
    end

    // Stage B: source y and partial source z.
    logic [TY_W-1:0] n_b_ty, n_b_tzp, r_b_ty, r_b_tzp;
    logic            r_b_vld, r_b_func;
    logic [AW-1:0]   r_b_laddr;
    logic [DW-1:0]   r_b_ldata;
    logic [7:0]      r_b_x;

    always_comb begin
        n_b_ty  = {r_a_pyz[PROD_W-1], r_a_pyz}
                + {{(TY_W-32){r_y_offset[31]}}, r_y_offset};
        n_b_tzp = {r_a_pzy[PROD_W-1], r_a_pzy} + {r_a_pzz[PROD_W-1], r_a_pzz};
    end

    // Stage C: source z.
    logic [TZ_W-1:0] n_c_tz, r_c_tz;
    logic [TY_W-1:0] r_c_ty;
    logic            r_c_vld, r_c_func;
    logic [AW-1:0]   r_c_laddr;
    logic [DW-1:0]   r_c_ldata;
    logic [7:0]      r_c_x;

    always_comb begin
        n_c_tz = {r_b_tzp[TY_W-1], r_b_tzp} + {{(TZ_W-32){r_z_offset[31]}}, r_z_offset};
    end

    // Stage D: bounds check, fractions and base addresses.
    logic [6:0]      ylm1, zlm1;
    logic [TY_W-1:0] ymax;
    logic [TZ_W-1:0] zmax;
    logic [AW-1:0]   ty_row, tz_pl;
    logic [XS_W-1:0] xsum;
    logic            n_d_ok;
    logic [AW-1:0]   n_d_base, n_d_base_r;
    logic            r_d_vld, r_d_func, r_d_ok;
    logic [AW-1:0]   r_d_base, r_d_base_r, r_d_laddr;
    logic [DW-1:0]   r_d_ldata;
    logic [15:0]     r_d_wy, r_d_wz;

    always_comb begin
        ylm1   = {1'b0, r_y_limit} - 7'd1;
        zlm1   = {1'b0, r_z_limit} - 7'd1;
        ymax   = {{(TY_W-23){ylm1[6]}}, ylm1, 16'd0};
        zmax   = {{(TZ_W-23){zlm1[6]}}, zlm1, 16'd0};
        n_d_ok = ~r_c_ty[TY_W-1] && ($signed(r_c_ty) <= $signed(ymax))
              && ~r_c_tz[TZ_W-1] && ($signed(r_c_tz) <= $signed(zmax));
        ty_row = r_c_ty[16 +: AW];
        tz_pl  = r_c_tz[16 +: AW];
        xsum   = XS_W'(r_start_x) + XS_W'(r_c_x);
        n_d_base   = (ty_row << vdbw_pkg::X_BITS) + (tz_pl << vdbw_pkg::ZB) + AW'(xsum);
        n_d_base_r = ((ty_row + AW'(1)) << vdbw_pkg::X_BITS) + (tz_pl << vdbw_pkg::ZB)
                   + AW'(xsum);
    end

    // Stage E: store access and bilinear weights.
    vdbw_pkg::t_bank_req bank_req   [vdbw_pkg::BANKS];
    logic [DW-1:0]       bank_rdata [vdbw_pkg::BANKS];

    for (genvar g = 0; g < vdbw_pkg::BANKS; g++) begin : g_bank
        localparam logic [1:0] BK = 2'(g);
        logic [AW-1:0] sel, rd_addr;

        assign sel     = (r_d_base[vdbw_pkg::YB] != BK[0]) ? r_d_base_r : r_d_base;
        assign rd_addr = sel + ((sel[vdbw_pkg::ZB] != BK[1]) ? PLANE : '0);

        assign bank_req[g] = '{
            we:    r_d_vld && (r_d_func == vdbw_pkg::FUNC_LOAD)
                   && (vdbw_pkg::bank_code(r_d_laddr) == BK),
            waddr: vdbw_pkg::bank_index(r_d_laddr),
            wdata: r_d_ldata,
            re:    r_d_vld && (r_d_func == vdbw_pkg::FUNC_COMPUTE),
            raddr: vdbw_pkg::bank_index(rd_addr)
        };

        vdbw_bank u_bank (
            .i_clk   (i_clk),
            .i_req   (bank_req[g]),
            .o_rdata (bank_rdata[g])
        );
    end

    logic [16:0]    iy, iz;
    logic [W_W-1:0] n_e_wa, n_e_wb, n_e_wc, n_e_wd;
    logic [W_W-1:0] r_e_wa, r_e_wb, r_e_wc, r_e_wd;
    logic           r_e_vld, r_e_ok, r_e_b5, r_e_b10, r_e_c10;

    always_comb begin
        iy     = 17'(1 << 16) - 17'(r_d_wy);
        iz     = 17'(1 << 16) - 17'(r_d_wz);
        n_e_wa = W_W'(34'(iy) * 34'(iz));
        n_e_wb = W_W'(34'(iy) * 34'(r_d_wz));
        n_e_wc = W_W'(34'(r_d_wy) * 34'(iz));
        n_e_wd = W_W'(34'(r_d_wy) * 34'(r_d_wz));
    end

    // Stage F: weighted neighbours.
    logic [DW-1:0]  va, vb, vc, vd;
    logic [T_W-1:0] n_f_ta, n_f_tb, n_f_tc, n_f_td;
    logic [T_W-1:0] r_f_ta, r_f_tb, r_f_tc, r_f_td;
    logic           r_f_vld, r_f_ok;

    always_comb begin
        va     = bank_rdata[{r_e_b10, r_e_b5}];
        vb     = bank_rdata[{~r_e_b10, r_e_b5}];
        vc     = bank_rdata[{r_e_c10, ~r_e_b5}];
        vd     = bank_rdata[{~r_e_c10, ~r_e_b5}];
        n_f_ta = T_W'(r_e_wa) * T_W'(va);
        n_f_tb = T_W'(r_e_wb) * T_W'(vb);
        n_f_tc = T_W'(r_e_wc) * T_W'(vc);
        n_f_td = T_W'(r_e_wd) * T_W'(vd);
    end

    // Output stage: sum, round and saturate.
    logic [T_W-1:0] acc;
    logic [DW-1:0]  n_value;
    logic           r_valid, r_in_range;
    logic [DW-1:0]  r_voxel_value;

    always_comb begin
        acc = r_f_ta + r_f_tb + r_f_tc + r_f_td + ROUND;
        if (!r_f_ok) begin
            n_value = '0;
        end else if (acc[T_W-1]) begin
            n_value = '1;
        end else begin
            n_value = acc[T_W-2 -: DW];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
            r_b_vld <= 1'b0;
            r_c_vld <= 1'b0;
            r_d_vld <= 1'b0;
            r_e_vld <= 1'b0;
            r_f_vld <= 1'b0;
            r_valid <= 1'b0;
        end else begin
            r_a_vld <= i_start && !o_busy;
            r_b_vld <= r_a_vld;
            r_c_vld <= r_b_vld;
            r_d_vld <= r_c_vld;
            r_e_vld <= r_d_vld && (r_d_func == vdbw_pkg::FUNC_COMPUTE);
            r_f_vld <= r_e_vld;
            r_valid <= r_f_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_a_pyz   <= n_a_pyz;
        r_a_pzy   <= n_a_pzy;
        r_a_pzz   <= n_a_pzz;
        r_a_func  <= i_func;
        r_a_laddr <= i_load_addr;
        r_a_ldata <= i_load_data;
        r_a_x     <= i_out_x;

        r_b_ty    <= n_b_ty;
        r_b_tzp   <= n_b_tzp;
        r_b_func  <= r_a_func;
        r_b_laddr <= r_a_laddr;
        r_b_ldata <= r_a_ldata;
        r_b_x     <= r_a_x;

        r_c_ty    <= r_b_ty;
        r_c_tz    <= n_c_tz;
        r_c_func  <= r_b_func;
        r_c_laddr <= r_b_laddr;
        r_c_ldata <= r_b_ldata;
        r_c_x     <= r_b_x;

        r_d_ok     <= n_d_ok;
        r_d_base   <= n_d_base;
        r_d_base_r <= n_d_base_r;
        r_d_wy     <= r_c_ty[15:0];
        r_d_wz     <= r_c_tz[15:0];
        r_d_func   <= r_c_func;
        r_d_laddr  <= r_c_laddr;
        r_d_ldata  <= r_c_ldata;

        r_e_ok  <= r_d_ok;
        r_e_b5  <= r_d_base[vdbw_pkg::YB];
        r_e_b10 <= r_d_base[vdbw_pkg::ZB];
        r_e_c10 <= r_d_base_r[vdbw_pkg::ZB];
        r_e_wa  <= n_e_wa;
        r_e_wb  <= n_e_wb;
        r_e_wc  <= n_e_wc;
        r_e_wd  <= n_e_wd;

        r_f_ok <= r_e_ok;
        r_f_ta <= n_f_ta;
        r_f_tb <= n_f_tb;
        r_f_tc <= n_f_tc;
        r_f_td <= n_f_td;

        r_voxel_value <= n_value;
        r_in_range    <= r_f_ok;
    end

    assign o_valid       = r_valid;
    assign o_voxel_value = r_voxel_value;
    assign o_in_range    = r_in_range;

`ifndef SYNTHESIS
    a_compute_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy && i_func == vdbw_pkg::FUNC_COMPUTE) |-> ##7 o_valid)
        else $error("compute request produced no result");

    a_result_has_request: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(i_start && !o_busy && i_func == vdbw_pkg::FUNC_COMPUTE, 7))
        else $error("result without a matching compute request");

    a_skipped_is_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_in_range) |-> (o_voxel_value == '0))
        else $error("out-of-range result carries a nonzero value");
`endif

endmodule

`default_nettype wire
